// File: hdl/dual_square_wave_stereo_mixer_assert.svh
// ----------------------------------------------------------------------------
// dual square wave stereo mixer assertion macros
// concurrent checks that compile away for synthesis
// ----------------------------------------------------------------------------
`ifndef DUAL_SQUARE_WAVE_STEREO_MIXER_ASSERT_SVH
`define DUAL_SQUARE_WAVE_STEREO_MIXER_ASSERT_SVH

`ifndef SYNTHESIS

// consequent must hold in the same cycle
`define DSWM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dswm assertion failed");

// consequent must hold in the next cycle
`define DSWM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dswm assertion failed");

`else

`define DSWM_ASSERT_NOW(label, clk, rst, ante, cons)
`define DSWM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: hdl/dswm_pkg.sv
// ----------------------------------------------------------------------------
// dswm_pkg
// shared widths, constants and types of the dual square wave stereo mixer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dswm_pkg;

   localparam int SCALE_W  = 46;
   localparam int PHASE_W  = 32;
   localparam int RATE_W   = 11;
   localparam int DUTY_W   = 2;
   localparam int VOL_W    = 4;
   localparam int EN_W     = 4;
   localparam int MASTER_W = 3;
   localparam int SAMPLE_W = 9;
   localparam int DSR_W    = 12;
   localparam int REM_W    = 11;

   localparam int PADDR_W  = 4;
   localparam int PDATA_W  = 64;
   localparam int REG_IDX_W = 1;

   localparam logic [REG_IDX_W-1:0] REG_PHASE_SCALE = 1'b0;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 46'd11728124029;
   localparam logic [DSR_W-1:0]   RATE_BASE   = 12'd2048;

   localparam logic [PHASE_W-1:0] DUTY_THR [4] = '{
      32'h2000_0000, 32'h4000_0000, 32'h8000_0000, 32'hC000_0000
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START_A,
      ST_WAIT_A,
      ST_START_B,
      ST_WAIT_B,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// File: hdl/dswm_if.sv
// ----------------------------------------------------------------------------
// dswm channel interfaces
// request and response channels with valid / ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dswm_req_if;
   logic                                valid;
   logic                                ready;
   logic [dswm_pkg::RATE_W-1:0]         rate_a;
   logic [dswm_pkg::DUTY_W-1:0]         duty_a;
   logic [dswm_pkg::VOL_W-1:0]          volume_a;
   logic [dswm_pkg::RATE_W-1:0]         rate_b;
   logic [dswm_pkg::DUTY_W-1:0]         duty_b;
   logic [dswm_pkg::VOL_W-1:0]          volume_b;
   logic [dswm_pkg::EN_W-1:0]           side_enables;
   logic [dswm_pkg::MASTER_W-1:0]       left_master;
   logic [dswm_pkg::MASTER_W-1:0]       right_master;

   modport source (
      output valid, rate_a, duty_a, volume_a, rate_b, duty_b, volume_b,
             side_enables, left_master, right_master,
      input  ready
   );
   modport sink (
      input  valid, rate_a, duty_a, volume_a, rate_b, duty_b, volume_b,
             side_enables, left_master, right_master,
      output ready
   );
endinterface

interface dswm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [dswm_pkg::SAMPLE_W-1:0] left_sample;
   logic signed [dswm_pkg::SAMPLE_W-1:0] right_sample;

   modport source (output valid, left_sample, right_sample, input ready);
   modport sink (input valid, left_sample, right_sample, output ready);
endinterface

// File: hdl/dual_square_wave_stereo_mixer.sv
// ----------------------------------------------------------------------------
// dual_square_wave_stereo_mixer
// two square-wave channels with 32-bit phase, mixed to a stereo sample
// items: a new item is accepted only in idle, once the previous result
//   is loaded into the output register; the shared divider (two quotient
//   bits per cycle) runs once per channel
// reset: synchronous, clears both phases, phase scale to its default
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dual_square_wave_stereo_mixer_assert.svh"

module dual_square_wave_stereo_mixer (
   input  logic                           clock,
   input  logic                           reset,
   dswm_req_if.sink                       req,
   dswm_rsp_if.source                     rsp,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [dswm_pkg::PADDR_W-1:0]   paddr,
   input  logic [dswm_pkg::PDATA_W-1:0]   pwdata,
   output logic [dswm_pkg::PDATA_W-1:0]   prdata,
   output logic                           pready
);

   localparam int SUM_W  = 6;
   localparam int PROD_W = 10;

   dswm_pkg::state_type state_ff, state_in;

   logic [dswm_pkg::SCALE_W-1:0]   phase_scale;
   logic [dswm_pkg::PHASE_W-1:0]   phase_a_ff, phase_a_in;
   logic [dswm_pkg::PHASE_W-1:0]   phase_b_ff, phase_b_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   logic [dswm_pkg::DSR_W-1:0]     dsr_a_ff, dsr_b_ff;
   logic [dswm_pkg::VOL_W-1:0]     va_ff, vb_ff;
   logic [dswm_pkg::EN_W-1:0]      en_ff;
   logic [dswm_pkg::MASTER_W-1:0]  lm_ff, rm_ff;
   logic                           lvl_a_ff, lvl_b_ff;
   logic signed [dswm_pkg::SAMPLE_W-1:0] left_ff, right_ff;

   logic                           accept;
   logic                           div_start;
   logic                           div_wait;
   logic                           load_out;
   logic [dswm_pkg::DSR_W-1:0]     div_dsr;
   logic [dswm_pkg::PHASE_W-1:0]   div_quo;
   dswm_pkg::div_stat_type         div_stat;

   logic signed [4:0]              term_a, term_b;
   logic signed [SUM_W-1:0]        ta6, tb6, sum_l, sum_r;
   logic signed [PROD_W-1:0]       prod_l, prod_r;

   dswm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .phase_scale (phase_scale)
   );

   dswm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (phase_scale),
      .divisor  (div_dsr),
      .quotient (div_quo),
      .stat     (div_stat)
   );

   assign req.ready = (state_ff == dswm_pkg::ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign div_dsr   = (state_ff == dswm_pkg::ST_START_B) ? dsr_b_ff : dsr_a_ff;
   assign div_wait  = (state_ff == dswm_pkg::ST_WAIT_A) || (state_ff == dswm_pkg::ST_WAIT_B);

   // sequencer
   always_comb begin
      state_in   = state_ff;
      div_start  = 1'b0;
      load_out   = 1'b0;
      phase_a_in = phase_a_ff;
      phase_b_in = phase_b_ff;
      unique case (state_ff)
         dswm_pkg::ST_IDLE: begin
            if (accept) state_in = dswm_pkg::ST_START_A;
         end
         dswm_pkg::ST_START_A: begin
            div_start = 1'b1;
            state_in  = dswm_pkg::ST_WAIT_A;
         end
         dswm_pkg::ST_WAIT_A: begin
            if (div_stat.done) begin
               phase_a_in = phase_a_ff + div_quo;
               state_in   = dswm_pkg::ST_START_B;
            end
         end
         dswm_pkg::ST_START_B: begin
            div_start = 1'b1;
            state_in  = dswm_pkg::ST_WAIT_B;
         end
         dswm_pkg::ST_WAIT_B: begin
            if (div_stat.done) begin
               phase_b_in = phase_b_ff + div_quo;
               state_in   = dswm_pkg::ST_OUT;
            end
         end
         dswm_pkg::ST_OUT: begin
            // wait until the output register is free
            if (!rsp_valid_ff || rsp.ready) begin
               load_out = 1'b1;
               state_in = dswm_pkg::ST_IDLE;
            end
         end
         default: state_in = dswm_pkg::ST_IDLE;
      endcase
   end

   // side mix
   always_comb begin
      term_a = lvl_a_ff ? signed'({1'b0, va_ff}) : -signed'({1'b0, va_ff});
      term_b = lvl_b_ff ? signed'({1'b0, vb_ff}) : -signed'({1'b0, vb_ff});
      ta6    = SUM_W'(term_a);
      tb6    = SUM_W'(term_b);
      sum_l  = (en_ff[0] ? ta6 : '0) + (en_ff[1] ? tb6 : '0);
      sum_r  = (en_ff[2] ? ta6 : '0) + (en_ff[3] ? tb6 : '0);
      prod_l = PROD_W'(sum_l) * PROD_W'(signed'({1'b0, lm_ff}));
      prod_r = PROD_W'(sum_r) * PROD_W'(signed'({1'b0, rm_ff}));
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dswm_pkg::ST_IDLE;
         phase_a_ff   <= '0;
         phase_b_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_a_ff   <= phase_a_in;
         phase_b_ff   <= phase_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item capture, level taken from the phase before its step
   always_ff @(posedge clock) begin
      if (accept) begin
         dsr_a_ff <= dswm_pkg::DSR_W'(dswm_pkg::RATE_BASE - {1'b0, req.rate_a});
         dsr_b_ff <= dswm_pkg::DSR_W'(dswm_pkg::RATE_BASE - {1'b0, req.rate_b});
         va_ff    <= req.volume_a;
         vb_ff    <= req.volume_b;
         en_ff    <= req.side_enables;
         lm_ff    <= req.left_master;
         rm_ff    <= req.right_master;
         lvl_a_ff <= (phase_a_ff < dswm_pkg::DUTY_THR[req.duty_a]);
         lvl_b_ff <= (phase_b_ff < dswm_pkg::DUTY_THR[req.duty_b]);
      end
      if (load_out) begin
         left_ff  <= prod_l[dswm_pkg::SAMPLE_W-1:0];
         right_ff <= prod_r[dswm_pkg::SAMPLE_W-1:0];
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.left_sample  = left_ff;
   assign rsp.right_sample = right_ff;

   `DSWM_ASSERT_NOW(a_start_div_idle, clock, reset, div_start, !div_stat.busy)
   `DSWM_ASSERT_NEXT(a_accept_blocks, clock, reset, accept, !req.ready)
   `DSWM_ASSERT_NOW(a_done_in_wait, clock, reset, div_stat.done, div_wait)
   `DSWM_ASSERT_NOW(a_load_out_free, clock, reset, load_out, !rsp_valid_ff || rsp.ready)

endmodule

// File: hdl/dswm_csr.sv
// ----------------------------------------------------------------------------
// dswm_csr
// apb register block holding the phase scale
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dswm_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [dswm_pkg::PADDR_W-1:0]   paddr,
   input  logic [dswm_pkg::PDATA_W-1:0]   pwdata,
   output logic [dswm_pkg::PDATA_W-1:0]   prdata,
   output logic                           pready,
   output logic [dswm_pkg::SCALE_W-1:0]   phase_scale
);

   logic [dswm_pkg::SCALE_W-1:0]   scale_ff;
   logic [dswm_pkg::SCALE_W-1:0]   scale_in;
   logic [dswm_pkg::REG_IDX_W-1:0] reg_idx;
   logic                           wr_en;

   // 8-byte register slots
   assign reg_idx = paddr[dswm_pkg::PADDR_W-1:3];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_comb begin
      scale_in = scale_ff;
      if (wr_en) begin
         unique case (reg_idx)
            dswm_pkg::REG_PHASE_SCALE: scale_in = pwdata[dswm_pkg::SCALE_W-1:0];
            default: scale_in = scale_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         dswm_pkg::REG_PHASE_SCALE: prdata = dswm_pkg::PDATA_W'(scale_ff);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= dswm_pkg::SCALE_RESET;
      end else begin
         scale_ff <= scale_in;
      end
   end

   assign phase_scale = scale_ff;

endmodule

// File: hdl/dswm_div.sv
// ----------------------------------------------------------------------------
// dswm_div
// radix-4 restoring divider, two quotient bits per cycle, low 32 bits kept
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dswm_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [dswm_pkg::SCALE_W-1:0]  dividend,
   input  logic [dswm_pkg::DSR_W-1:0]    divisor,
   output logic [dswm_pkg::PHASE_W-1:0]  quotient,
   output dswm_pkg::div_stat_type        stat
);

   localparam int ITER   = dswm_pkg::SCALE_W / 2;
   localparam int CNT_W  = $clog2(ITER);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(ITER - 1);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [dswm_pkg::SCALE_W-1:0]  dvd_ff, dvd_in;
   logic [dswm_pkg::DSR_W-1:0]    dsr_ff, dsr_in;
   logic [dswm_pkg::REM_W-1:0]    rem_ff, rem_in;
   logic [dswm_pkg::PHASE_W-1:0]  quo_ff, quo_in;

   logic [dswm_pkg::DSR_W-1:0]    t1, t2;
   logic                          ge1, ge2;
   logic [dswm_pkg::REM_W-1:0]    r1, r2;

   // two dependent shift-subtract steps
   always_comb begin
      t1  = {rem_ff, dvd_ff[dswm_pkg::SCALE_W-1]};
      ge1 = (t1 >= dsr_ff);
      r1  = ge1 ? dswm_pkg::REM_W'(t1 - dsr_ff) : t1[dswm_pkg::REM_W-1:0];
      t2  = {r1, dvd_ff[dswm_pkg::SCALE_W-2]};
      ge2 = (t2 >= dsr_ff);
      r2  = ge2 ? dswm_pkg::REM_W'(t2 - dsr_ff) : t2[dswm_pkg::REM_W-1:0];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[dswm_pkg::SCALE_W-3:0], 2'b00};
         rem_in = r2;
         quo_in = {quo_ff[dswm_pkg::PHASE_W-3:0], ge1, ge2};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule
